@@ rtl/qrm_pkg.sv @@
package qrm_pkg;

    localparam int unsigned QUAT_W            = 16;
    localparam int unsigned ELEM_W            = 16;
    localparam int unsigned OUT_FRAC_BITS_DEF = 14;

    // 16x16 signed product
    localparam int unsigned PROD_W = 2 * QUAT_W;
    // signed numerator: 2*(ab - cd) needs two bits over a product
    localparam int unsigned NUM_W  = PROD_W + 2;
    // norm up to 4 * 2^30
    localparam int unsigned NORM_W = PROD_W + 1;

    // width that holds a signed result of +/- 2^frac and the output field
    function automatic int unsigned ext_width(input int unsigned frac);
        return (frac + 2 > ELEM_W) ? frac + 2 : ELEM_W;
    endfunction

endpackage

@@ rtl/qrm_if.sv @@
interface qrm_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [qrm_pkg::QUAT_W-1:0]   quat_w;
    logic signed [qrm_pkg::QUAT_W-1:0]   quat_x;
    logic signed [qrm_pkg::QUAT_W-1:0]   quat_y;
    logic signed [qrm_pkg::QUAT_W-1:0]   quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

interface qrm_rot_if;
    logic                                valid;
    logic                                ready;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_00;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_01;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_02;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_10;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_11;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_12;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_20;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_21;
    logic signed [qrm_pkg::ELEM_W-1:0]   rot_22;
    logic                                zero_norm;

    modport source (output valid, output rot_00, output rot_01, output rot_02,
                    output rot_10, output rot_11, output rot_12, output rot_20,
                    output rot_21, output rot_22, output zero_norm, input ready);
    modport sink   (input valid, input rot_00, input rot_01, input rot_02,
                    input rot_10, input rot_11, input rot_12, input rot_20,
                    input rot_21, input rot_22, input zero_norm, output ready);
endinterface

@@ rtl/qrm_div_lane.sv @@
module qrm_div_lane #(
    parameter int unsigned OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic [OUT_FRAC_BITS+2:0]            en,
    input  logic signed [qrm_pkg::NUM_W-1:0]    num,
    input  logic [qrm_pkg::NORM_W-1:0]          norm_pipe [OUT_FRAC_BITS+2],
    output logic [qrm_pkg::ELEM_W-1:0]          elem
);

    localparam int unsigned STEPS = OUT_FRAC_BITS + 1;
    localparam int unsigned MAG_W = qrm_pkg::NORM_W;
    localparam int unsigned DIV_W = MAG_W + OUT_FRAC_BITS + 1;
    localparam int unsigned REM_W = qrm_pkg::NORM_W + 1;
    localparam int unsigned ACC_W = REM_W + STEPS;
    localparam int unsigned RES_W = OUT_FRAC_BITS + 2;
    localparam int unsigned EXT_W = qrm_pkg::ext_width(OUT_FRAC_BITS);
    localparam logic [STEPS-1:0] ONE_Q = STEPS'(1) << OUT_FRAC_BITS;

    // acc = {remainder, dividend bits not yet used / quotient bits}
    logic [ACC_W-1:0] acc_reg  [STEPS+1];
    logic [ACC_W-1:0] acc_next [STEPS+1];
    logic [STEPS:0]   neg_reg;
    logic [STEPS:0]   neg_next;
    logic [qrm_pkg::ELEM_W-1:0] elem_reg;
    logic [qrm_pkg::ELEM_W-1:0] elem_next;

    logic                    neg0;
    logic [MAG_W-1:0]        mag0;
    logic [DIV_W-1:0]        div0;
    logic [STEPS-1:0]        quo;
    logic [STEPS-1:0]        quo_sat;
    logic signed [RES_W-1:0] mag_s;
    logic signed [RES_W-1:0] val;
    logic signed [EXT_W-1:0] val_ext;

    // dividend = |num| * 2^F + norm/2 (round half away from zero)
    always_comb
    begin
        neg0        = num[qrm_pkg::NUM_W-1];
        mag0        = neg0 ? MAG_W'(-num) : MAG_W'(num);
        div0        = (DIV_W'(mag0) << OUT_FRAC_BITS) + DIV_W'(norm_pipe[0] >> 1);
        acc_next[0] = ACC_W'(div0);
        neg_next[0] = neg0;
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [ACC_W-1:0] sh;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;

        always_comb
        begin
            sh          = {acc_reg[k-1][ACC_W-2:0], 1'b0};
            rem         = sh[ACC_W-1:STEPS];
            dvs         = REM_W'(norm_pipe[k]);
            acc_next[k] = sh;
            if (rem >= dvs)
            begin
                acc_next[k] = {rem - dvs, sh[STEPS-1:1], 1'b1};
            end
            neg_next[k] = neg_reg[k-1];
        end
    end

    // saturate, apply sign, fit to field
    always_comb
    begin
        quo       = acc_reg[STEPS][STEPS-1:0];
        quo_sat   = (quo > ONE_Q) ? ONE_Q : quo;
        mag_s     = signed'({1'b0, quo_sat});
        val       = neg_reg[STEPS] ? -mag_s : mag_s;
        val_ext   = EXT_W'(val);
        elem_next = val_ext[qrm_pkg::ELEM_W-1:0];
    end

    for (genvar k = 0; k <= STEPS; k++)
    begin : g_reg
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                acc_reg[k] <= acc_next[k];
                neg_reg[k] <= neg_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STEPS+1])
        begin
            elem_reg <= elem_next;
        end
    end

    assign elem = elem_reg;

endmodule

@@ rtl/quaternion_to_rotation_matrix.sv @@
// Throughput: one word per cycle; the restoring divider retires one quotient bit
// per pipeline stage in each of the nine element lanes, which sets the depth.
// Stalls hold each stage; empty stages keep filling under output back-pressure.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module quaternion_to_rotation_matrix #(
    parameter int unsigned OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qrm_quat_if.sink    quat,
    qrm_rot_if.source   rot
);

    localparam int unsigned STEPS     = OUT_FRAC_BITS + 1;
    localparam int unsigned LANE_BASE = 3;
    localparam int unsigned NS        = LANE_BASE + STEPS + 2;
    localparam int unsigned EXT_W     = qrm_pkg::ext_width(OUT_FRAC_BITS);
    localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << OUT_FRAC_BITS;
    localparam logic [qrm_pkg::ELEM_W-1:0] ONE_ELEM = ONE_EXT[qrm_pkg::ELEM_W-1:0];
    localparam int ONE_INT = 1 << OUT_FRAC_BITS;

    localparam int unsigned QW = qrm_pkg::QUAT_W;
    localparam int unsigned PW = qrm_pkg::PROD_W;
    localparam int unsigned NW = qrm_pkg::NUM_W;
    localparam int unsigned RW = qrm_pkg::NORM_W;

    // ---------------- flow control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    assign en[NS-1] = ~v_reg[NS-1] | rot.ready;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = ~v_reg[i] | en[i+1];
    end

    assign v_next[0] = en[0] ? quat.valid : v_reg[0];
    for (genvar i = 1; i < NS; i++)
    begin : g_vld
        assign v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign quat.ready = en[0];

    // ---------------- stage 0: input capture
    logic signed [QW-1:0] w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg <= quat.quat_w;
            x_reg <= quat.quat_x;
            y_reg <= quat.quat_y;
            z_reg <= quat.quat_z;
        end
    end

    // ---------------- stage 1: products
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic [NS-1:1]        zero_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ww_reg      <= w_reg * w_reg;
            xx_reg      <= x_reg * x_reg;
            yy_reg      <= y_reg * y_reg;
            zz_reg      <= z_reg * z_reg;
            xy_reg      <= x_reg * y_reg;
            zw_reg      <= z_reg * w_reg;
            xz_reg      <= x_reg * z_reg;
            yw_reg      <= y_reg * w_reg;
            yz_reg      <= y_reg * z_reg;
            xw_reg      <= x_reg * w_reg;
            zero_reg[1] <= ((w_reg | x_reg | y_reg | z_reg) == '0);
        end
    end

    for (genvar i = 2; i < NS; i++)
    begin : g_zero
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // ---------------- stage 2: numerators and norm
    logic signed [NW-1:0] num_reg  [9];
    logic signed [NW-1:0] num_next [9];
    logic [RW-1:0]        nrm_reg  [STEPS+1];
    logic [RW-1:0]        nrm_next;

    always_comb
    begin
        num_next[0] = NW'(xx_reg) - NW'(yy_reg) - NW'(zz_reg) + NW'(ww_reg);
        num_next[1] = (NW'(xy_reg) - NW'(zw_reg)) <<< 1;
        num_next[2] = (NW'(xz_reg) + NW'(yw_reg)) <<< 1;
        num_next[3] = (NW'(xy_reg) + NW'(zw_reg)) <<< 1;
        num_next[4] = NW'(yy_reg) - NW'(xx_reg) - NW'(zz_reg) + NW'(ww_reg);
        num_next[5] = (NW'(yz_reg) - NW'(xw_reg)) <<< 1;
        num_next[6] = (NW'(xz_reg) - NW'(yw_reg)) <<< 1;
        num_next[7] = (NW'(yz_reg) + NW'(xw_reg)) <<< 1;
        num_next[8] = NW'(zz_reg) - NW'(xx_reg) - NW'(yy_reg) + NW'(ww_reg);
        nrm_next    = RW'(ww_reg) + RW'(xx_reg) + RW'(yy_reg) + RW'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            num_reg    <= num_next;
            nrm_reg[0] <= nrm_next;
        end
    end

    // norm travels beside the divider stages
    for (genvar k = 1; k <= STEPS; k++)
    begin : g_nrm
        always_ff @(posedge clk)
        begin
            if (en[2+k])
            begin
                nrm_reg[k] <= nrm_reg[k-1];
            end
        end
    end

    // ---------------- stages 3 .. NS-1: divider lanes
    logic [qrm_pkg::ELEM_W-1:0] elem [9];

    for (genvar e = 0; e < 9; e++)
    begin : g_lane
        qrm_div_lane #(
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .en        (en[NS-1:LANE_BASE]),
            .num       (num_reg[e]),
            .norm_pipe (nrm_reg),
            .elem      (elem[e])
        );
    end

    // ---------------- output word
    assign rot.valid     = v_reg[NS-1];
    assign rot.zero_norm = zero_reg[NS-1];
    assign rot.rot_00    = zero_reg[NS-1] ? ONE_ELEM : elem[0];
    assign rot.rot_01    = zero_reg[NS-1] ? '0       : elem[1];
    assign rot.rot_02    = zero_reg[NS-1] ? '0       : elem[2];
    assign rot.rot_10    = zero_reg[NS-1] ? '0       : elem[3];
    assign rot.rot_11    = zero_reg[NS-1] ? ONE_ELEM : elem[4];
    assign rot.rot_12    = zero_reg[NS-1] ? '0       : elem[5];
    assign rot.rot_20    = zero_reg[NS-1] ? '0       : elem[6];
    assign rot.rot_21    = zero_reg[NS-1] ? '0       : elem[7];
    assign rot.rot_22    = zero_reg[NS-1] ? ONE_ELEM : elem[8];

    // ---------------- assertions
    logic in_acc;
    logic out_acc;

    assign in_acc  = quat.valid & quat.ready;
    assign out_acc = rot.valid & rot.ready;

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) ==
            $countones($past(v_reg)) + $past(in_acc) - $past(out_acc)))
        else $error("pipeline word count mismatch");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !quat.ready |-> (&v_reg))
        else $error("input stalled with an empty stage");

    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rot.valid && (OUT_FRAC_BITS <= 14)) |->
            (rot.rot_00 <= ONE_INT && rot.rot_00 >= -ONE_INT &&
             rot.rot_01 <= ONE_INT && rot.rot_01 >= -ONE_INT))
        else $error("element outside +/- one");

endmodule

@@ bench/tb_top.sv @@
module tb_top;

    localparam int unsigned OUT_FRAC  = qrm_pkg::OUT_FRAC_BITS_DEF;
    localparam int          N_RANDOM  = 1380;
    localparam int          PHASE1_AT = 470;
    localparam int          PHASE2_AT = 940;
    localparam int          HOLD_AT   = 300;
    localparam int          HOLD_LEN  = 120;
    localparam int          DRAIN_AT  = 700;
    localparam int          TAIL      = 60;

    typedef struct packed {
        logic signed [qrm_pkg::QUAT_W-1:0] w;
        logic signed [qrm_pkg::QUAT_W-1:0] x;
        logic signed [qrm_pkg::QUAT_W-1:0] y;
        logic signed [qrm_pkg::QUAT_W-1:0] z;
    } quat_word_t;

    typedef struct packed {
        logic [8:0][qrm_pkg::ELEM_W-1:0] elem;
        logic                            zero_norm;
    } rot_word_t;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    qrm_quat_if quat_ch ();
    qrm_rot_if  rot_ch ();

    quaternion_to_rotation_matrix #(
        .OUT_FRAC_BITS(OUT_FRAC)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat_ch),
        .rot   (rot_ch)
    );

    quat_word_t quat_pending [$];
    rot_word_t  rot_expected [$];
    quat_word_t quat_next;
    int         quat_offer_cnt = 0;
    int         quat_acc_cnt   = 0;
    int         mismatch_cnt   = 0;
    int         rot_hold_left  = 0;
    bit         rot_hold_done  = 1'b0;
    bit         drain_done     = 1'b0;

    // |num| * 2^OUT_FRAC / norm, rounded half away from zero, saturated to one
    function automatic logic [qrm_pkg::ELEM_W-1:0] fixed_ratio(input longint num,
                                                               input longint norm);
        longint one;
        longint mag;
        longint q;
        one = longint'(1) << OUT_FRAC;
        mag = (num < 0) ? -num : num;
        q   = ((mag << OUT_FRAC) + norm / 2) / norm;
        if (q > one)
            q = one;
        if (num < 0)
            q = -q;
        return q[qrm_pkg::ELEM_W-1:0];
    endfunction

    function automatic rot_word_t rotation_of(input quat_word_t qt);
        longint    w, x, y, z;
        longint    ww, xx, yy, zz, n;
        longint    one;
        rot_word_t r;
        w  = $signed(qt.w);
        x  = $signed(qt.x);
        y  = $signed(qt.y);
        z  = $signed(qt.z);
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        n  = ww + xx + yy + zz;
        one = longint'(1) << OUT_FRAC;
        r = '0;
        if (n == 0)
        begin
            r.elem[0]   = one[qrm_pkg::ELEM_W-1:0];
            r.elem[4]   = one[qrm_pkg::ELEM_W-1:0];
            r.elem[8]   = one[qrm_pkg::ELEM_W-1:0];
            r.zero_norm = 1'b1;
        end
        else
        begin
            r.elem[0] = fixed_ratio(xx - yy - zz + ww, n);
            r.elem[1] = fixed_ratio(2 * (x * y - z * w), n);
            r.elem[2] = fixed_ratio(2 * (x * z + y * w), n);
            r.elem[3] = fixed_ratio(2 * (x * y + z * w), n);
            r.elem[4] = fixed_ratio(-xx + yy - zz + ww, n);
            r.elem[5] = fixed_ratio(2 * (y * z - x * w), n);
            r.elem[6] = fixed_ratio(2 * (x * z - y * w), n);
            r.elem[7] = fixed_ratio(2 * (y * z + x * w), n);
            r.elem[8] = fixed_ratio(-xx - yy + zz + ww, n);
        end
        return r;
    endfunction

    function automatic logic [qrm_pkg::QUAT_W-1:0] rand_part(input int unsigned kind);
        case (kind)
            0: return qrm_pkg::QUAT_W'($urandom);
            1: return qrm_pkg::QUAT_W'($urandom_range(16) - 8);
            2:
            begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default: return qrm_pkg::QUAT_W'($signed(qrm_pkg::QUAT_W'($urandom))
                                             >>> $urandom_range(15));
        endcase
    endfunction

    function automatic quat_word_t random_quat();
        quat_word_t  qt;
        int unsigned kind;
        kind = $urandom_range(11);
        if (kind <= 3)
        begin
            qt.w = rand_part(0);
            qt.x = rand_part(0);
            qt.y = rand_part(0);
            qt.z = rand_part(0);
        end
        else if (kind <= 5)
        begin
            qt.w = rand_part(kind - 3);
            qt.x = rand_part(kind - 3);
            qt.y = rand_part(kind - 3);
            qt.z = rand_part(kind - 3);
        end
        else if (kind == 6)
        begin
            // one dominant axis
            qt.w = rand_part(1);
            qt.x = rand_part(1);
            qt.y = rand_part(1);
            qt.z = rand_part(1);
            case ($urandom_range(3))
                0: qt.w = rand_part(0);
                1: qt.x = rand_part(0);
                2: qt.y = rand_part(0);
                default: qt.z = rand_part(0);
            endcase
        end
        else if (kind == 7)
            qt = ($urandom_range(3) == 0) ? '0 : {4{rand_part(1)}};
        else
        begin
            qt.w = rand_part($urandom_range(3));
            qt.x = rand_part($urandom_range(3));
            qt.y = rand_part($urandom_range(3));
            qt.z = rand_part($urandom_range(3));
        end
        return qt;
    endfunction

    function automatic int send_idle_pct();
        if (quat_acc_cnt < PHASE1_AT)
            return 20;
        else if (quat_acc_cnt < PHASE2_AT)
            return 49;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (quat_acc_cnt < PHASE1_AT)
            return 49;
        else if (quat_acc_cnt < PHASE2_AT)
            return 20;
        return 0;
    endfunction

    task automatic check_rot(input rot_word_t got);
        rot_word_t want;
        if (rot_expected.size() == 0)
        begin
            mismatch_cnt++;
            $display("%0t: unexpected rotation word, expected none got %h", $time, got);
            return;
        end
        want = rot_expected.pop_front();
        for (int k = 0; k < 9; k++)
        begin
            if (got.elem[k] !== want.elem[k])
            begin
                mismatch_cnt++;
                $display("%0t: rot_%0d%0d expected %0d got %0d", $time, k / 3, k % 3,
                         $signed(want.elem[k]), $signed(got.elem[k]));
            end
        end
        if (got.zero_norm !== want.zero_norm)
        begin
            mismatch_cnt++;
            $display("%0t: zero_norm expected %0b got %0b", $time,
                     want.zero_norm, got.zero_norm);
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rot_ch.valid && rot_ch.ready)
                check_rot({rot_ch.rot_22, rot_ch.rot_21, rot_ch.rot_20,
                           rot_ch.rot_12, rot_ch.rot_11, rot_ch.rot_10,
                           rot_ch.rot_02, rot_ch.rot_01, rot_ch.rot_00,
                           rot_ch.zero_norm});
            if (quat_ch.valid && quat_ch.ready)
            begin
                rot_expected.push_back(rotation_of({quat_ch.quat_w, quat_ch.quat_x,
                                                    quat_ch.quat_y, quat_ch.quat_z}));
                quat_acc_cnt <= quat_acc_cnt + 1;
            end
        end
    end

    // quaternion driver
    always @(negedge clk)
    begin
        if (!rst_n)
            quat_ch.valid <= 1'b0;
        else if (!quat_ch.valid || quat_acc_cnt == quat_offer_cnt)
        begin
            if (quat_offer_cnt == DRAIN_AT && !drain_done)
            begin
                quat_ch.valid <= 1'b0;
                if (rot_expected.size() == 0)
                    drain_done <= 1'b1;
            end
            else if (quat_pending.size() == 0 || $urandom_range(99) < send_idle_pct())
                quat_ch.valid <= 1'b0;
            else
            begin
                quat_next = quat_pending.pop_front();
                quat_ch.quat_w <= quat_next.w;
                quat_ch.quat_x <= quat_next.x;
                quat_ch.quat_y <= quat_next.y;
                quat_ch.quat_z <= quat_next.z;
                quat_ch.valid  <= 1'b1;
                quat_offer_cnt <= quat_offer_cnt + 1;
            end
        end
    end

    // rotation receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            rot_ch.ready <= 1'b0;
        else if (rot_hold_left != 0)
        begin
            rot_ch.ready  <= 1'b0;
            rot_hold_left <= rot_hold_left - 1;
        end
        else if (!rot_hold_done && quat_acc_cnt >= HOLD_AT)
        begin
            rot_ch.ready  <= 1'b0;
            rot_hold_left <= HOLD_LEN;
            rot_hold_done <= 1'b1;
        end
        else
            rot_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end

    initial
    begin
        rst_n          = 1'b0;
        quat_ch.valid  = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        rot_ch.ready   = 1'b0;

        // zero quaternion, axis extremes, all-extreme and small unnormalized words
        quat_pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
        quat_pending.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'sd0});
        quat_pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
        quat_pending.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        quat_pending.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
        quat_pending.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
        quat_pending.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
        quat_pending.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd1});
        quat_pending.push_back('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
        quat_pending.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
        quat_pending.push_back('{16'sd1, 16'sd1, 16'sd1, 16'sd0});
        quat_pending.push_back('{16'sd23170, 16'sd23170, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd3, -16'sd2, 16'sd5, 16'sd7});
        quat_pending.push_back('{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0});
        quat_pending.push_back('{16'sd0, 16'sd0, -16'sd1, 16'sd32767});
        quat_pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        for (int i = 0; i < N_RANDOM; i++)
            quat_pending.push_back(random_quat());

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (quat_pending.size() != 0 || quat_ch.valid || rot_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (mismatch_cnt == 0 && rot_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
